FILE: sv/rsi_pkg.sv
// Shared types and constants for the ray/sphere intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_MIN_DISTANCE = 3'd4
  } cfg_reg_t;

  localparam int RADIUS_RESET   = 65536;
  localparam int MIN_DIST_RESET = 66;

  typedef struct packed {
    logic valid;
    logic miss;
  } flag_t;

endpackage
`default_nettype wire

FILE: sv/rsi_front.sv
// Front pipeline: center offset, dot products, squared terms and discriminant.
`timescale 1ns / 1ps
`default_nettype none
module rsi_front #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int RAD_W      = 102
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic signed [COORD_BITS-1:0] center_z,
  input  wire logic        [COORD_BITS-2:0] radius,
  input  wire logic signed [COORD_BITS-1:0] origin_x,
  input  wire logic signed [COORD_BITS-1:0] origin_y,
  input  wire logic signed [COORD_BITS-1:0] origin_z,
  input  wire logic signed [COORD_BITS-1:0] dir_x,
  input  wire logic signed [COORD_BITS-1:0] dir_y,
  input  wire logic signed [COORD_BITS-1:0] dir_z,
  input  wire logic        [COORD_BITS-2:0] closest_distance,
  output rsi_pkg::flag_t                    flg_o,
  output logic signed [2*COORD_BITS+3-FRAC_BITS:0] h_o,
  output logic        [COORD_BITS-2:0]      closest_o,
  output logic        [RAD_W-1:0]           rad_o
);

  localparam int OW   = COORD_BITS + 1;
  localparam int PW   = 2 * OW;
  localparam int SUMW = PW + 2;
  localparam int HW   = SUMW - FRAC_BITS;
  localparam int CW   = SUMW + 1;
  localparam int RRW  = 2 * (COORD_BITS - 1);
  localparam int LOW  = HW / 2;
  localparam int HIW  = HW - LOW;
  localparam int DW   = ((2 * HW > CW) ? 2 * HW : CW) + 1;

  // stage 1
  logic                   v1;
  logic signed [OW-1:0]   ocx, ocy, ocz;
  logic signed [COORD_BITS-1:0] dx1, dy1, dz1;
  logic [COORD_BITS-2:0]  cl1;
  // stage 2
  logic                   v2;
  logic signed [PW-1:0]   mdx, mdy, mdz, mxx, myy, mzz;
  logic [RRW-1:0]         rr;
  logic [COORD_BITS-2:0]  cl2;
  // stage 3
  logic                   v3;
  logic signed [HW-1:0]   h3;
  logic signed [CW-1:0]   c3;
  logic [COORD_BITS-2:0]  cl3;
  // stage 4
  logic                   v4;
  logic signed [2*HIW-1:0]     p_hi;
  logic signed [HIW+LOW:0]     p_mid;
  logic [2*LOW-1:0]            p_lo;
  logic signed [HW-1:0]   h4;
  logic signed [CW-1:0]   c4;
  logic [COORD_BITS-2:0]  cl4;
  // stage 5
  logic signed [DW-1:0]   disc5;

  logic signed [SUMW-1:0] hsum, sqsum;
  logic signed [DW-1:0]   disc;

  // cross term counted twice: shift by LOW + 1
  always_comb begin
    hsum  = SUMW'(mdx) + SUMW'(mdy) + SUMW'(mdz);
    sqsum = SUMW'(mxx) + SUMW'(myy) + SUMW'(mzz);
    disc  = (DW'(p_hi) <<< (2 * LOW)) + (DW'(p_mid) <<< (LOW + 1))
          + DW'($signed({1'b0, p_lo})) - DW'(c4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      flg_o <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      flg_o.valid <= v4;
      flg_o.miss  <= disc[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ocx <= $signed({center_x[COORD_BITS-1], center_x})
           - $signed({origin_x[COORD_BITS-1], origin_x});
      ocy <= $signed({center_y[COORD_BITS-1], center_y})
           - $signed({origin_y[COORD_BITS-1], origin_y});
      ocz <= $signed({center_z[COORD_BITS-1], center_z})
           - $signed({origin_z[COORD_BITS-1], origin_z});
      dx1 <= dir_x;
      dy1 <= dir_y;
      dz1 <= dir_z;
      cl1 <= closest_distance;

      mdx <= dx1 * ocx;
      mdy <= dy1 * ocy;
      mdz <= dz1 * ocz;
      mxx <= ocx * ocx;
      myy <= ocy * ocy;
      mzz <= ocz * ocz;
      rr  <= radius * radius;
      cl2 <= cl1;

      h3  <= hsum[SUMW-1:FRAC_BITS];
      c3  <= CW'(sqsum) - CW'($signed({1'b0, rr}));
      cl3 <= cl2;

      // h*h as three partial products
      p_hi  <= $signed(h3[HW-1:LOW]) * $signed(h3[HW-1:LOW]);
      p_mid <= $signed(h3[HW-1:LOW]) * $signed({1'b0, h3[LOW-1:0]});
      p_lo  <= h3[LOW-1:0] * h3[LOW-1:0];
      h4    <= h3;
      c4    <= c3;
      cl4   <= cl3;

      disc5     <= disc;
      h_o       <= h4;
      closest_o <= cl4;
    end
  end

  assign rad_o = RAD_W'(disc5[DW-2:0]);

endmodule
`default_nettype wire

FILE: sv/rsi_sqrt.sv
// Pipelined floor square root, one root bit per stage, with sideband data.
`timescale 1ns / 1ps
`default_nettype none
module rsi_sqrt #(
  parameter int SW     = 51,
  parameter int SIDE_W = 82
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire rsi_pkg::flag_t    flg_i,
  input  wire logic [2*SW-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output rsi_pkg::flag_t         flg_o,
  output logic      [SW-1:0]     root_o,
  output logic      [SIDE_W-1:0] side_o
);

  localparam int RW   = 2 * SW;
  localparam int RMW  = SW + 1;
  localparam int CURW = SW + 3;

  rsi_pkg::flag_t    flg  [0:SW];
  logic [RMW-1:0]    rem  [0:SW];
  logic [SW-1:0]     root [0:SW];
  logic [RW-1:0]     rad  [0:SW];
  logic [SIDE_W-1:0] side [0:SW];

  assign flg[0]  = flg_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [CURW-1:0] cur, trial, diff;
    logic            ge;

    always_comb begin
      cur   = {rem[k], rad[k][RW-1:RW-2]};
      trial = {root[k], 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        flg[k+1] <= '0;
      end else if (en) begin
        flg[k+1] <= flg[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
        root[k+1] <= {root[k][SW-2:0], ge};
        rad[k+1]  <= {rad[k][RW-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign flg_o  = flg[SW];
  assign root_o = root[SW];
  assign side_o = side[SW];

endmodule
`default_nettype wire

FILE: sv/ray_sphere_intersection.sv
// Top level: configuration registers, front pipeline, square root, root selection.
// One ray enters per clock while in_stall is low, and each ray yields one
// result word. SW = DW/2 is the square root width (52 stages at the default
// 32/16 format); the pipeline as a whole holds while a result waits under
// out_stall. Registers are at byte address 4*i (8*i when COORD_BITS exceeds
// 32) and should be written while no ray is in flight.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_intersection #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int DATA_W    = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_W    = $clog2(5 * DATA_W / 8)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_W-1:0]            paddr,
  input  wire logic [DATA_W-1:0]            pwdata,
  output logic      [DATA_W-1:0]            prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] origin_x,
  input  wire logic signed [COORD_BITS-1:0] origin_y,
  input  wire logic signed [COORD_BITS-1:0] origin_z,
  input  wire logic signed [COORD_BITS-1:0] dir_x,
  input  wire logic signed [COORD_BITS-1:0] dir_y,
  input  wire logic signed [COORD_BITS-1:0] dir_z,
  input  wire logic        [COORD_BITS-2:0] closest_distance,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              hit,
  output logic             [COORD_BITS-2:0] distance,
  output logic                              far_root
);

  localparam int OW     = COORD_BITS + 1;
  localparam int SUMW   = 2 * OW + 2;
  localparam int HW     = SUMW - FRAC_BITS;
  localparam int CW     = SUMW + 1;
  localparam int DW     = ((2 * HW > CW) ? 2 * HW : CW) + 1;
  localparam int SW     = DW / 2;
  localparam int RW     = 2 * SW;
  localparam int DISTW  = COORD_BITS - 1;
  localparam int SIDE_W = HW + DISTW;
  localparam int RTW    = ((HW > SW) ? HW : SW) + 2;
  localparam int STEP_SH = $clog2(DATA_W / 8);

  logic signed [COORD_BITS-1:0] center_x, center_y, center_z;
  logic [DISTW-1:0]             radius, min_distance;
  rsi_pkg::cfg_reg_t            idx;
  logic                         wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = rsi_pkg::cfg_reg_t'(paddr[ADDR_W-1:STEP_SH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      center_z     <= '0;
      radius       <= DISTW'(rsi_pkg::RADIUS_RESET);
      min_distance <= DISTW'(rsi_pkg::MIN_DIST_RESET);
    end else if (wr) begin
      unique case (idx)
        rsi_pkg::REG_CENTER_X:     center_x     <= pwdata[COORD_BITS-1:0];
        rsi_pkg::REG_CENTER_Y:     center_y     <= pwdata[COORD_BITS-1:0];
        rsi_pkg::REG_CENTER_Z:     center_z     <= pwdata[COORD_BITS-1:0];
        rsi_pkg::REG_RADIUS:       radius       <= pwdata[DISTW-1:0];
        rsi_pkg::REG_MIN_DISTANCE: min_distance <= pwdata[DISTW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rsi_pkg::REG_CENTER_X:     prdata = DATA_W'(unsigned'(center_x));
      rsi_pkg::REG_CENTER_Y:     prdata = DATA_W'(unsigned'(center_y));
      rsi_pkg::REG_CENTER_Z:     prdata = DATA_W'(unsigned'(center_z));
      rsi_pkg::REG_RADIUS:       prdata = DATA_W'(radius);
      rsi_pkg::REG_MIN_DISTANCE: prdata = DATA_W'(min_distance);
      default:                   prdata = '0;
    endcase
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  rsi_pkg::flag_t          f_flg, s_flg;
  logic signed [HW-1:0]    f_h;
  logic [DISTW-1:0]        f_cl;
  logic [RW-1:0]           f_rad;
  logic [SW-1:0]           s_root;
  logic [SIDE_W-1:0]       s_side;

  rsi_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .RAD_W     (RW)
  ) u_front (
    .clk, .rst, .en, .in_valid,
    .center_x, .center_y, .center_z, .radius,
    .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z, .closest_distance,
    .flg_o     (f_flg),
    .h_o       (f_h),
    .closest_o (f_cl),
    .rad_o     (f_rad)
  );

  rsi_sqrt #(
    .SW    (SW),
    .SIDE_W(SIDE_W)
  ) u_sqrt (
    .clk, .rst, .en,
    .flg_i  (f_flg),
    .rad_i  (f_rad),
    .side_i ({f_h, f_cl}),
    .flg_o  (s_flg),
    .root_o (s_root),
    .side_o (s_side)
  );

  logic signed [RTW-1:0] r0, r1, lo, hi;
  logic                  ok0, ok1;
  logic [DISTW-1:0]      cl_s;

  always_comb begin
    cl_s = s_side[DISTW-1:0];
    r0   = RTW'($signed(s_side[SIDE_W-1:DISTW])) - RTW'($signed({1'b0, s_root}));
    r1   = RTW'($signed(s_side[SIDE_W-1:DISTW])) + RTW'($signed({1'b0, s_root}));
    lo   = $signed(RTW'(min_distance));
    hi   = $signed(RTW'(cl_s));
    ok0  = !s_flg.miss && (r0 > lo) && (hi > r0);
    ok1  = !s_flg.miss && (r1 > lo) && (hi > r1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_flg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= ok0 || ok1;
      far_root <= !ok0 && ok1;
      priority if (ok0) begin
        distance <= r0[DISTW-1:0];
      end else if (ok1) begin
        distance <= r1[DISTW-1:0];
      end else begin
        distance <= cl_s;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/rsi_checker.sv
// Port-level checks for the ray/sphere intersection block, with bind.
`timescale 1ns / 1ps
`default_nettype none
module rsi_checker #(
  parameter int COORD_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  hit,
  input wire logic                  far_root,
  input wire logic [COORD_BITS-2:0] distance
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_stall_only_on_back: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  a_far_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && far_root) |-> hit)
    else $error("far_root without hit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(distance) && $stable(hit)))
    else $error("stalled word changed");

endmodule

bind ray_sphere_intersection rsi_checker #(.COORD_BITS(COORD_BITS)) u_rsi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .far_root  (far_root),
  .distance  (distance)
);
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the ray/sphere intersection pipeline.
`timescale 1ns / 1ps
module testbench;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic [30:0] closest;
  } ray_t;

  typedef struct {
    logic hit;
    logic [30:0] dst;
    logic far;
  } hit_t;

  class hit_board;
    logic signed [31:0] cx, cy, cz;
    logic [30:0] radius, min_dist;
    hit_t pending[$];
    int errors;

    function new();
      cx = 0; cy = 0; cz = 0;
      radius = 31'(rsi_pkg::RADIUS_RESET);
      min_dist = 31'(rsi_pkg::MIN_DIST_RESET);
      errors = 0;
    endfunction

    function wide_t floor_sqrt(wide_t num);
      wide_t res, b, t;
      res = 0;
      b = wide_t'(1) <<< 158;
      while (b > num) b = b >> 2;
      while (b != 0) begin
        t = res + b;
        if (num >= t) begin
          num = num - t;
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_ray(ray_t r);
      wide_t ocx, ocy, ocz, h, c, disc, s, lo, hi, rr;
      wide_t root[2];
      hit_t e;
      ocx = wide_t'(cx) - wide_t'(r.ox);
      ocy = wide_t'(cy) - wide_t'(r.oy);
      ocz = wide_t'(cz) - wide_t'(r.oz);
      h = (wide_t'(r.dx) * ocx + wide_t'(r.dy) * ocy + wide_t'(r.dz) * ocz) >>> 16;
      rr = {129'b0, radius};
      c = ocx * ocx + ocy * ocy + ocz * ocz - rr * rr;
      disc = h * h - c;
      e.hit = 0;
      e.dst = r.closest;
      e.far = 0;
      if (disc >= 0) begin
        s = floor_sqrt(disc);
        root[0] = h - s;
        root[1] = h + s;
        lo = {129'b0, min_dist};
        hi = {129'b0, r.closest};
        for (int k = 1; k >= 0; k--) begin
          if (root[k] > lo && root[k] < hi) begin
            e.hit = 1;
            e.dst = root[k][30:0];
            e.far = (k == 1);
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check_hit(logic hit, logic [30:0] dst, logic far);
      hit_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: hit=%0b dist=%0d", hit, dst);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || dst !== e.dst || far !== e.far) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit=%0b dist=%0d far=%0b, got hit=%0b dist=%0d far=%0b",
                   e.hit, e.dst, e.far, hit, dst, far);
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic [30:0] closest_distance, distance;
  logic hit, far_root;
  int snd_idle, rcv_idle;
  hit_board sb;

  ray_sphere_intersection u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .closest_distance(closest_distance),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .distance(distance), .far_root(far_root)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    ray_t r;
    if (!rst && in_valid && !in_stall) begin
      r.ox = origin_x; r.oy = origin_y; r.oz = origin_z;
      r.dx = dir_x; r.dy = dir_y; r.dz = dir_z;
      r.closest = closest_distance;
      sb.note_ray(r);
    end
    if (!rst && out_valid && !out_stall) sb.check_hit(hit, distance, far_root);
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < rcv_idle);
  end

  task write_reg(input rsi_pkg::cfg_reg_t idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      rsi_pkg::REG_CENTER_X: sb.cx = val;
      rsi_pkg::REG_CENTER_Y: sb.cy = val;
      rsi_pkg::REG_CENTER_Z: sb.cz = val;
      rsi_pkg::REG_RADIUS: sb.radius = val[30:0];
      rsi_pkg::REG_MIN_DISTANCE: sb.min_dist = val[30:0];
      default: ;
    endcase
  endtask

  task send_ray(input ray_t r);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
    dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
    closest_distance <= r.closest;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task send_axis(input int oz, input int dz, input int ox, input int closest);
    ray_t r;
    r.ox = ox; r.oy = 0; r.oz = oz;
    r.dx = 0; r.dy = 0; r.dz = dz;
    r.closest = 31'(closest);
    send_ray(r);
  endtask

  // mostly rays aimed near the sphere, some pure noise
  function ray_t aimed_ray();
    ray_t r;
    if ($urandom_range(99) < 20) begin
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
      r.closest = 31'($urandom);
    end else begin
      r.ox = sb.cx - $signed($urandom_range(1310720)) + 655360;
      r.oy = sb.cy - $signed($urandom_range(1310720)) + 655360;
      r.oz = sb.cz - $signed($urandom_range(1310720)) + 655360;
      r.dx = $signed($urandom_range(131072)) - 65536;
      r.dy = $signed($urandom_range(131072)) - 65536;
      r.dz = $signed($urandom_range(131072)) - 65536;
      r.closest = ($urandom_range(3) == 0) ? 31'h7fffffff : 31'($urandom_range(1500000));
    end
    return r;
  endfunction

  task random_rays(input int n);
    for (int i = 0; i < n; i++) send_ray(aimed_ray());
  endtask

  task random_config();
    write_reg(rsi_pkg::REG_CENTER_X, $signed($urandom_range(2000000)) - 1000000);
    write_reg(rsi_pkg::REG_CENTER_Y, $signed($urandom_range(2000000)) - 1000000);
    write_reg(rsi_pkg::REG_CENTER_Z, $signed($urandom_range(2000000)) - 1000000);
    write_reg(rsi_pkg::REG_RADIUS, $urandom_range(600000));
    write_reg(rsi_pkg::REG_MIN_DISTANCE, $urandom_range(1000));
  endtask

  initial begin
    ray_t r;
    sb = new();
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; out_stall = 0;
    origin_x = 0; origin_y = 0; origin_z = 0;
    dir_x = 0; dir_y = 0; dir_z = 0; closest_distance = 0;
    snd_idle = 38; rcv_idle = 63;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // unit sphere at origin, reset settings
    send_axis(-327680, 65536, 0, 262144);      // closest equals near root
    send_axis(-327680, 65536, 0, 393216);      // near root hits
    send_axis(-327680, 65536, 0, 31'h7fffffff);
    send_axis(0, 65536, 0, 31'h7fffffff);      // inside: far root
    send_axis(-65602, 65536, 0, 31'h7fffffff); // near root equals min distance
    send_axis(-327680, 131072, 0, 31'h7fffffff); // non-unit direction
    send_axis(-327680, 65536, 327680, 31'h7fffffff); // negative discriminant
    send_axis(-327680, -65536, 0, 31'h7fffffff); // sphere behind
    send_axis(-327680, 65536, 0, 0);
    r.ox = 32'sh7fffffff; r.oy = 32'sh7fffffff; r.oz = 32'sh7fffffff;
    r.dx = 32'sh80000000; r.dy = 32'sh80000000; r.dz = 32'sh80000000;
    r.closest = 31'h7fffffff;
    send_ray(r);
    r.ox = 32'sh80000000; r.oy = 32'sh80000000; r.oz = 32'sh80000000;
    send_ray(r);
    r.dx = 32'sh7fffffff; r.dy = 32'sh7fffffff; r.dz = 32'sh7fffffff;
    send_ray(r);
    r.ox = 0; r.oy = 0; r.oz = 0; r.dx = 0; r.dy = 0; r.dz = 0;
    send_ray(r);
    drain();

    random_config();
    random_rays(200);
    drain();              // sender holds until everything is back
    random_rays(200);
    drain();

    snd_idle = 63; rcv_idle = 38;
    write_reg(rsi_pkg::REG_CENTER_X, 32'h7fffffff);
    write_reg(rsi_pkg::REG_CENTER_Y, 32'h80000000);
    write_reg(rsi_pkg::REG_CENTER_Z, 32'h7fffffff);
    write_reg(rsi_pkg::REG_RADIUS, 32'h7fffffff);
    write_reg(rsi_pkg::REG_MIN_DISTANCE, 0);
    random_rays(200);
    drain();
    random_config();
    random_rays(200);
    drain();

    snd_idle = 0; rcv_idle = 0;
    write_reg(rsi_pkg::REG_CENTER_X, 32'h80000000);
    write_reg(rsi_pkg::REG_CENTER_Y, 32'h7fffffff);
    write_reg(rsi_pkg::REG_CENTER_Z, 32'h80000000);
    write_reg(rsi_pkg::REG_RADIUS, 0);
    write_reg(rsi_pkg::REG_MIN_DISTANCE, 32'h7fffffff);
    random_rays(100);
    drain();
    random_config();
    random_rays(200);
    drain();

    repeat (70) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
